// ===== hw/rtl/dss_pkg.sv =====
// shared constants, types and lookup functions of the decimal seven-segment scanner
package dss_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int VALUE_W        = 32;
    localparam int CONV_W         = 27;
    localparam int HALF_W         = 14;
    localparam int PAIR_W         = 7;
    localparam int CODE_W         = 4;
    localparam int POS_W          = 3;
    localparam int ANODE_W        = 8;
    localparam int SEG_W          = 8;
    localparam int MAX_DIGITS     = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [CODE_W-1:0] CODE_E     = 4'd10;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

    localparam logic [POS_W-1:0]   LAST_RESET  = 3'd7;
    localparam logic [ANODE_W-1:0] ANODE_RESET = 8'hFE;
    localparam logic [SEG_W-1:0]   SEG_OFF     = 8'hFF;

    // reciprocal constants, exact over the ranges they see
    localparam int                DIV10K_SHIFT = 41;
    localparam logic [27:0]       DIV10K_MUL   = 28'd219902326;
    localparam logic [CONV_W-1:0] TEN_THOUSAND = 27'd10000;
    localparam int                DIV100_SHIFT = 20;
    localparam logic [HALF_W-1:0] DIV100_MUL   = 14'd10486;
    localparam logic [HALF_W-1:0] HUNDRED      = 14'd100;
    localparam int                DIV10_SHIFT  = 10;
    localparam logic [HALF_W-1:0] DIV10_MUL    = 14'd103;
    localparam logic [PAIR_W-1:0] TEN          = 7'd10;

    localparam logic [SEG_W-1:0] SEG_0 = 8'b00111111;
    localparam logic [SEG_W-1:0] SEG_1 = 8'b00000110;
    localparam logic [SEG_W-1:0] SEG_2 = 8'b01011011;
    localparam logic [SEG_W-1:0] SEG_3 = 8'b01001111;
    localparam logic [SEG_W-1:0] SEG_4 = 8'b01100110;
    localparam logic [SEG_W-1:0] SEG_5 = 8'b01101101;
    localparam logic [SEG_W-1:0] SEG_6 = 8'b01111101;
    localparam logic [SEG_W-1:0] SEG_7 = 8'b00000111;
    localparam logic [SEG_W-1:0] SEG_8 = 8'b01111111;
    localparam logic [SEG_W-1:0] SEG_9 = 8'b01101111;
    localparam logic [SEG_W-1:0] SEG_E = 8'b01111001;

    typedef struct packed {
        logic vld;
        logic tick;
    } t_ctl;

    function automatic longint unsigned pow10_m1(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p - 1;
    endfunction

    // active-low segment pattern, decimal point off
    function automatic logic [SEG_W-1:0] seg_decode(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] s;
        case (code)
            4'd0:    s = ~SEG_0;
            4'd1:    s = ~SEG_1;
            4'd2:    s = ~SEG_2;
            4'd3:    s = ~SEG_3;
            4'd4:    s = ~SEG_4;
            4'd5:    s = ~SEG_5;
            4'd6:    s = ~SEG_6;
            4'd7:    s = ~SEG_7;
            4'd8:    s = ~SEG_8;
            4'd9:    s = ~SEG_9;
            CODE_E:  s = ~SEG_E;
            default: s = SEG_OFF;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/decimal_seven_segment_scanner.sv =====
// top level of the eight-digit multiplexed decimal seven-segment scanner
//
// input channel: i_valid / o_stall with i_req_type and i_value; a load request
// (i_req_type 0) converts i_value to decimal digits with leading zeros blanked,
// showing E on every digit when it does not fit; a tick request (type 1) moves
// the active-low anode one place left, wrapping after the configured last one
// output channel: o_valid / i_stall; one result per request with the anode
// pattern, active-low segments of the selected digit and the scan position
// configuration: i_cfg_wr_en writes i_cfg_wr_data as the last scan position
// o_valid follows accept through the five register stages of the
// reciprocal-multiply digit converter and then the result register
// throughput is one request per cycle; all stages advance together and hold
// while a result waits with i_stall high, which raises o_stall
// reset: digits blank, scan position zero, rightmost anode lit, last index 7,
// pipeline empty
module decimal_seven_segment_scanner #(
    parameter int NUM_DIGITS = dss_pkg::NUM_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [dss_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dss_pkg::ANODE_W-1:0]   o_anode_select,
    output logic [dss_pkg::SEG_W-1:0]     o_segments,
    output logic [dss_pkg::POS_W-1:0]     o_scan_position,
    input  logic                          i_cfg_wr_en,
    input  logic [dss_pkg::POS_W-1:0]     i_cfg_wr_data
);

    logic                       en;
    dss_pkg::t_ctl              conv_ctl;
    logic [dss_pkg::CODE_W-1:0] conv_codes [NUM_DIGITS];

    // whole pipeline holds while a finished result is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    dss_conv #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_ctl      (conv_ctl),
        .o_codes    (conv_codes)
    );

    dss_scan #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_ctl           (conv_ctl),
        .i_codes         (conv_codes),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_valid         (o_valid),
        .o_anode_select  (o_anode_select),
        .o_segments      (o_segments),
        .o_scan_position (o_scan_position)
    );

endmodule

// ===== hw/rtl/dss_conv.sv =====
// pipelined binary to decimal digit code converter with blanking and overflow
module dss_conv #(
    parameter int NUM_DIGITS = dss_pkg::NUM_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic                           i_req_type,
    input  logic [dss_pkg::VALUE_W-1:0]    i_value,
    output dss_pkg::t_ctl                  o_ctl,
    output logic [dss_pkg::CODE_W-1:0]     o_codes [NUM_DIGITS]
);

    localparam logic [dss_pkg::VALUE_W-1:0] LIMIT =
        dss_pkg::VALUE_W'(dss_pkg::pow10_m1(NUM_DIGITS));

    // stage 0: input register
    dss_pkg::t_ctl                  r0_ctl;
    logic [dss_pkg::CONV_W-1:0]     r0_val;
    logic                           r0_ovf;
    // stage 1: value / 10000
    dss_pkg::t_ctl                  r1_ctl;
    logic [dss_pkg::CONV_W-1:0]     r1_val;
    logic [dss_pkg::HALF_W-1:0]     r1_q;
    logic                           r1_ovf;
    // stage 2: upper and lower four digits
    dss_pkg::t_ctl                  r2_ctl;
    logic [dss_pkg::HALF_W-1:0]     r2_hi;
    logic [dss_pkg::HALF_W-1:0]     r2_lo;
    logic                           r2_ovf;
    // stage 3: halves / 100
    dss_pkg::t_ctl                  r3_ctl;
    logic [dss_pkg::HALF_W-1:0]     r3_hi;
    logic [dss_pkg::HALF_W-1:0]     r3_lo;
    logic [dss_pkg::PAIR_W-1:0]     r3_hq;
    logic [dss_pkg::PAIR_W-1:0]     r3_lq;
    logic                           r3_ovf;
    // stage 4: four digit pairs, lowest first
    dss_pkg::t_ctl                  r4_ctl;
    logic [dss_pkg::PAIR_W-1:0]     r4_pair [4];
    logic                           r4_ovf;

    logic [54:0]                    n1_prod;
    logic [dss_pkg::CONV_W-1:0]     n2_lo;
    logic [27:0]                    n3_hprod;
    logic [27:0]                    n3_lprod;
    logic [dss_pkg::HALF_W-1:0]     n4_hrem;
    logic [dss_pkg::HALF_W-1:0]     n4_lrem;
    logic [dss_pkg::CODE_W-1:0]     dig [dss_pkg::MAX_DIGITS];
    logic [dss_pkg::MAX_DIGITS-1:0] nz;

    assign n1_prod  = 55'(r0_val) * 55'(dss_pkg::DIV10K_MUL);
    assign n2_lo    = r1_val - dss_pkg::CONV_W'(r1_q) * dss_pkg::TEN_THOUSAND;
    assign n3_hprod = 28'(r2_hi) * 28'(dss_pkg::DIV100_MUL);
    assign n3_lprod = 28'(r2_lo) * 28'(dss_pkg::DIV100_MUL);
    assign n4_hrem  = r3_hi - dss_pkg::HALF_W'(r3_hq) * dss_pkg::HUNDRED;
    assign n4_lrem  = r3_lo - dss_pkg::HALF_W'(r3_lq) * dss_pkg::HUNDRED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r0_ctl <= '{vld: i_valid, tick: (i_req_type == dss_pkg::REQ_TICK)};
            r1_ctl <= r0_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_val     <= i_value[dss_pkg::CONV_W-1:0];
            r0_ovf     <= (i_value > LIMIT);
            r1_val     <= r0_val;
            r1_q       <= n1_prod[dss_pkg::DIV10K_SHIFT +: dss_pkg::HALF_W];
            r1_ovf     <= r0_ovf;
            r2_hi      <= r1_q;
            r2_lo      <= n2_lo[dss_pkg::HALF_W-1:0];
            r2_ovf     <= r1_ovf;
            r3_hi      <= r2_hi;
            r3_lo      <= r2_lo;
            r3_hq      <= n3_hprod[dss_pkg::DIV100_SHIFT +: dss_pkg::PAIR_W];
            r3_lq      <= n3_lprod[dss_pkg::DIV100_SHIFT +: dss_pkg::PAIR_W];
            r3_ovf     <= r2_ovf;
            r4_pair[0] <= n4_lrem[dss_pkg::PAIR_W-1:0];
            r4_pair[1] <= r3_lq;
            r4_pair[2] <= n4_hrem[dss_pkg::PAIR_W-1:0];
            r4_pair[3] <= r3_hq;
            r4_ovf     <= r3_ovf;
        end
    end

    // split each pair into tens and ones
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            logic [dss_pkg::HALF_W-1:0] tprod;
            logic [dss_pkg::CODE_W-1:0] tens;
            logic [dss_pkg::PAIR_W-1:0] ones;
            tprod = dss_pkg::HALF_W'(r4_pair[p]) * dss_pkg::DIV10_MUL;
            tens  = tprod[dss_pkg::DIV10_SHIFT +: dss_pkg::CODE_W];
            ones  = r4_pair[p] - dss_pkg::PAIR_W'(tens) * dss_pkg::TEN;
            dig[2*p]   = ones[dss_pkg::CODE_W-1:0];
            dig[2*p+1] = tens;
        end
    end

    // nonzero at this weight or above
    always_comb begin
        nz[dss_pkg::MAX_DIGITS-1] = |dig[dss_pkg::MAX_DIGITS-1];
        for (int j = dss_pkg::MAX_DIGITS - 2; j >= 0; j--) begin
            nz[j] = nz[j+1] | (|dig[j]);
        end
    end

    // entry NUM_DIGITS-1 holds the ones place
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r4_ovf) begin
                o_codes[k] = dss_pkg::CODE_E;
            end else if ((k == NUM_DIGITS - 1) || nz[NUM_DIGITS-1-k]) begin
                o_codes[k] = dig[NUM_DIGITS-1-k];
            end else begin
                o_codes[k] = dss_pkg::CODE_BLANK;
            end
        end
    end

    assign o_ctl = r4_ctl;

endmodule

// ===== hw/rtl/dss_scan.sv =====
// digit store, scan position, configuration register and result register
module dss_scan #(
    parameter int NUM_DIGITS = dss_pkg::NUM_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  dss_pkg::t_ctl                 i_ctl,
    input  logic [dss_pkg::CODE_W-1:0]    i_codes [NUM_DIGITS],
    input  logic                          i_cfg_wr_en,
    input  logic [dss_pkg::POS_W-1:0]     i_cfg_wr_data,
    output logic                          o_valid,
    output logic [dss_pkg::ANODE_W-1:0]   o_anode_select,
    output logic [dss_pkg::SEG_W-1:0]     o_segments,
    output logic [dss_pkg::POS_W-1:0]     o_scan_position
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [dss_pkg::POS_W-1:0] TOP_IDX = dss_pkg::POS_W'(NUM_DIGITS - 1);

    logic [dss_pkg::CODE_W-1:0]  r_codes [NUM_DIGITS];
    logic [dss_pkg::CODE_W-1:0]  n_codes [NUM_DIGITS];
    logic [dss_pkg::POS_W-1:0]   r_pos;
    logic [dss_pkg::POS_W-1:0]   n_pos;
    logic [dss_pkg::ANODE_W-1:0] r_anode;
    logic [dss_pkg::ANODE_W-1:0] n_anode;
    logic [dss_pkg::SEG_W-1:0]   r_seg;
    logic [dss_pkg::SEG_W-1:0]   n_seg;
    logic [dss_pkg::POS_W-1:0]   r_last;
    logic                        r_vld;
    logic [dss_pkg::POS_W-1:0]   eff_last;
    logic [dss_pkg::POS_W-1:0]   sel_diff;
    logic                        step;

    assign step     = i_en && i_ctl.vld;
    assign eff_last = (r_last > TOP_IDX) ? TOP_IDX : r_last;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            n_codes[k] = i_ctl.tick ? r_codes[k] : i_codes[k];
        end
        if (!i_ctl.tick) begin
            n_pos = r_pos;
        end else if (r_pos >= eff_last) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 3'd1;
        end
        n_anode  = ~(dss_pkg::ANODE_W'(1) << n_pos);
        sel_diff = eff_last - n_pos;
        if (n_pos > eff_last) begin
            n_seg = dss_pkg::SEG_OFF;
        end else begin
            n_seg = dss_pkg::seg_decode(n_codes[sel_diff[IDX_W-1:0]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_codes[k] <= dss_pkg::CODE_BLANK;
            end
            r_pos   <= '0;
            r_anode <= dss_pkg::ANODE_RESET;
            r_vld   <= 1'b0;
        end else begin
            if (i_en) begin
                r_vld <= i_ctl.vld;
            end
            if (step) begin
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    r_codes[k] <= n_codes[k];
                end
                r_pos   <= n_pos;
                r_anode <= n_anode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_seg <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= dss_pkg::LAST_RESET;
        end else if (i_cfg_wr_en) begin
            r_last <= i_cfg_wr_data;
        end
    end

    assign o_valid         = r_vld;
    assign o_anode_select  = r_anode;
    assign o_segments      = r_seg;
    assign o_scan_position = r_pos;

    a_anode_one_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(~r_anode))
        else $error("anode pattern has not exactly one active digit");

    a_anode_tracks_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anode == ~(dss_pkg::ANODE_W'(1) << r_pos))
        else $error("anode pattern disagrees with scan position");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_ctl.tick && (r_pos >= eff_last)) |=> (r_pos == '0))
        else $error("scan did not wrap after the last position");

    a_load_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_ctl.tick) |=> $stable(r_pos))
        else $error("load request moved the scan position");

    a_dp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_seg[dss_pkg::SEG_W-1])
        else $error("decimal point lit");

endmodule
